[hdl/kef_pkg.sv]
// ----------------------------------------------------------------------------
// kef_pkg
// shared types, constants and counter helpers for the keypad event queue
// ----------------------------------------------------------------------------
package kef_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CNT_MOD     = 2 * QUEUE_DEPTH;
    localparam int CNT_W       = $clog2(CNT_MOD);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int KEY_W       = 8;
    localparam int CFG_IDX_W   = 8;

    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [CNT_W:0]          t_qn;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic signed [KEY_W-1:0] t_key;

    localparam t_qn  QN_DEPTH  = t_qn'(QUEUE_DEPTH);
    localparam t_qn  QN_MOD    = t_qn'(CNT_MOD);
    localparam t_qn  QN_SAT    = t_qn'(7);
    localparam t_cnt CNT_LAST  = t_cnt'(CNT_MOD - 1);
    localparam t_key KEY_NONE  = -8'sd1;
    localparam t_key KEY_ZERO  = 8'sd0;

    localparam logic [2:0] REQ_PUSH      = 3'd0;
    localparam logic [2:0] REQ_POP       = 3'd1;
    localparam logic [2:0] REQ_POP_LAST  = 3'd2;
    localparam logic [2:0] REQ_TAIL      = 3'd3;
    localparam logic [2:0] REQ_READ_PAIR = 3'd4;
    localparam logic [2:0] REQ_FLUSH     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_PAIR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_PAIR   = CFG_IDX_W'(1);

    typedef struct packed {
        logic [2:0] req_type;
        t_key       key_code;
        logic       shift_down;
        logic       alt_down;
    } t_req;

    typedef struct packed {
        t_key       key_out;
        logic       key_valid;
        t_key       second_key;
        logic [1:0] pair_count;
        logic       room_left;
        logic       queue_empty;
        logic [2:0] free_slots;
    } t_res;

    function automatic t_cnt kef_bump(input t_cnt c);
        return (c == CNT_LAST) ? '0 : t_cnt'(c + t_cnt'(1));
    endfunction

    function automatic t_cnt kef_dec(input t_cnt c);
        return (c == '0) ? CNT_LAST : t_cnt'(c - t_cnt'(1));
    endfunction

    function automatic t_qn kef_queued(input t_cnt w, input t_cnt r);
        t_qn t;
        if (w >= r) begin
            t = t_qn'(w) - t_qn'(r);
        end else begin
            t = t_qn'(w) + QN_MOD - t_qn'(r);
        end
        return t;
    endfunction

    function automatic t_idx kef_slot(input t_cnt c, input logic [1:0] back);
        t_qn t;
        t = t_qn'(c) + QN_MOD - t_qn'(back);
        if (t >= QN_MOD) begin
            t = t - QN_MOD;
        end
        if (t >= QN_DEPTH) begin
            t = t - QN_DEPTH;
        end
        return t[IDX_W-1:0];
    endfunction

endpackage

[hdl/kef_if.sv]
// ----------------------------------------------------------------------------
// kef_if
// valid/ready channels for requests, results and register writes
// ----------------------------------------------------------------------------
interface kef_req_if import kef_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kef_res_if import kef_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kef_cfg_if import kef_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_key                 data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/kef_in_stage.sv]
// ----------------------------------------------------------------------------
// kef_in_stage
// input register holding one request until the queue core takes it
// ----------------------------------------------------------------------------
module kef_in_stage import kef_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_req o_req
);

    logic r_valid;
    t_req r_req;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

[hdl/kef_core.sv]
// ----------------------------------------------------------------------------
// kef_core
// ring storage, read/write counters, request decode and result register
// ----------------------------------------------------------------------------
module kef_core import kef_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    input  t_key i_shift_code,
    input  t_key i_alt_code,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    t_key r_store [QUEUE_DEPTH];
    t_cnt r_rd;
    t_cnt r_wr;
    logic r_res_valid;
    t_res r_res;

    t_cnt n_rd;
    t_cnt n_wr;
    t_res n_res;
    logic wr_en;
    t_idx wr_idx;
    t_cnt rd_eff;
    t_qn  qn;
    t_qn  qn_after;
    t_qn  free_now;
    t_key newest;
    t_key older;
    logic adv;

    assign o_ready = !r_res_valid || i_ready;
    assign adv     = i_valid && o_ready;
    assign o_valid = r_res_valid;
    assign o_res   = r_res;

    always_comb begin
        qn      = kef_queued(r_wr, r_rd);
        n_rd    = r_rd;
        n_wr    = r_wr;
        wr_en   = 1'b0;
        wr_idx  = kef_slot(r_wr, 2'd0);
        rd_eff  = r_rd;
        newest  = r_store[kef_slot(r_wr, 2'd1)];
        older   = r_store[kef_slot(r_wr, 2'd2)];
        n_res   = '0;
        case (i_req.req_type) inside
            REQ_PUSH: begin
                if (qn < QN_DEPTH) begin
                    wr_en = 1'b1;
                    n_wr  = kef_bump(r_wr);
                end
            end
            REQ_POP, REQ_POP_LAST: begin
                if (i_req.req_type == REQ_POP_LAST && qn > t_qn'(1)) begin
                    rd_eff = kef_dec(r_wr);
                end
                n_rd = rd_eff;
                if (rd_eff != r_wr) begin
                    n_res.key_out   = r_store[kef_slot(rd_eff, 2'd0)];
                    n_res.key_valid = 1'b1;
                    n_rd            = kef_bump(rd_eff);
                end else begin
                    n_res.key_out = KEY_NONE;
                end
            end
            REQ_TAIL: begin
                if (qn != '0) begin
                    n_res.key_out   = r_store[kef_slot(r_rd, 2'd1)];
                    n_res.key_valid = 1'b1;
                end else begin
                    n_res.key_out = KEY_NONE;
                end
            end
            REQ_READ_PAIR: begin
                if ((i_req.shift_down || i_req.alt_down) && newest != KEY_ZERO) begin
                    n_res.key_out    = newest;
                    n_res.second_key = i_req.shift_down ? i_shift_code : i_alt_code;
                    n_res.pair_count = 2'd2;
                    n_res.key_valid  = 1'b1;
                end else if (qn > t_qn'(1)) begin
                    n_res.key_out    = older;
                    n_res.second_key = newest;
                    n_res.pair_count = 2'd2;
                    n_res.key_valid  = 1'b1;
                end else if (qn != '0) begin
                    n_res.key_out    = newest;
                    n_res.pair_count = 2'd1;
                    n_res.key_valid  = 1'b1;
                end
            end
            REQ_FLUSH: begin
                n_rd = '0;
                n_wr = '0;
            end
            default: begin
            end
        endcase
        qn_after          = kef_queued(n_wr, n_rd);
        free_now          = QN_DEPTH - qn_after;
        if (free_now > QN_SAT) begin
            free_now = QN_SAT;
        end
        n_res.room_left   = qn_after < QN_DEPTH;
        n_res.queue_empty = n_rd == n_wr;
        n_res.free_slots  = free_now[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_store[i] <= KEY_ZERO;
            end
        end else if (adv) begin
            r_rd <= n_rd;
            r_wr <= n_wr;
            if (wr_en) begin
                r_store[wr_idx] <= i_req.key_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_ready) begin
            r_res_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kef_queued(r_wr, r_rd) <= QN_DEPTH)
        else $error("queue fill exceeds depth");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && i_req.req_type == REQ_FLUSH |=> r_rd == '0 && r_wr == '0)
        else $error("flush left counters nonzero");

    a_push_bumps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && i_req.req_type == REQ_PUSH && qn < QN_DEPTH
        |=> r_wr == kef_bump($past(r_wr)))
        else $error("push into open queue did not advance write counter");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_res.queue_empty == (r_rd == r_wr))
        else $error("empty flag disagrees with counters");

endmodule

[hdl/keypad_event_fifo_top.sv]
// ----------------------------------------------------------------------------
// keypad_event_fifo_top
// datapath: a request is held in the input stage register, then its result in the core result register
// throughput: one request per cycle while the result channel is not stalled
// reset: synchronous active low, clears counters, ring entries and pair codes
// ----------------------------------------------------------------------------
module keypad_event_fifo_top import kef_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kef_req_if.sink     i_req,
    kef_res_if.source   o_res,
    kef_cfg_if.sink     i_cfg
);

    t_key r_shift_code;
    t_key r_alt_code;
    logic stg_valid;
    logic stg_ready;
    t_req stg_req;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_code <= KEY_ZERO;
            r_alt_code   <= KEY_ZERO;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SHIFT_PAIR: r_shift_code <= i_cfg.data;
                CFG_ALT_PAIR:   r_alt_code   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    kef_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_req   (i_req.data),
        .o_valid (stg_valid),
        .i_ready (stg_ready),
        .o_req   (stg_req)
    );

    kef_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (stg_valid),
        .o_ready      (stg_ready),
        .i_req        (stg_req),
        .i_shift_code (r_shift_code),
        .i_alt_code   (r_alt_code),
        .o_valid      (o_res.valid),
        .i_ready      (o_res.ready),
        .o_res        (o_res.data)
    );

endmodule
